// ===== hw/rtl/quantized_vector_matrix_product_assert.svh =====
// assertion macros for the quantized vector-matrix product
`ifndef QUANTIZED_VECTOR_MATRIX_PRODUCT_ASSERT_SVH
`define QUANTIZED_VECTOR_MATRIX_PRODUCT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define QVMP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define QVMP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define QVMP_ASSERT_IMP(lbl, ante, cons)
`define QVMP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/qvmp_pkg.sv =====
// shared types and constants of the quantized vector-matrix product
package qvmp_pkg;

   localparam int MAX_COLS_DEF  = 64;
   localparam int MAX_DEPTH_DEF = 4096;

   localparam int BYTE_W        = 8;
   localparam int ZERO_W        = 9;
   localparam int OPND_W        = 10;
   localparam int SUM_W         = 32;
   localparam int COL_IDX_W     = 6;
   localparam int COL_COUNT_W   = 7;
   localparam int DEPTH_COUNT_W = 13;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [COL_COUNT_W-1:0]   COL_COUNT_RST   = COL_COUNT_W'(64);
   localparam logic [DEPTH_COUNT_W-1:0] DEPTH_COUNT_RST = DEPTH_COUNT_W'(1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A_IS_SIGNED   = 3'd0,
      CSR_B_IS_SIGNED   = 3'd1,
      CSR_A_ZERO        = 3'd2,
      CSR_SHARED_B_ZERO = 3'd3,
      CSR_B_ZERO_COMMON = 3'd4,
      CSR_COLUMN_COUNT  = 3'd5,
      CSR_DEPTH_COUNT   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic last_col;
   } pos_flags_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_last_row;
      logic advance;
   } pipe_stat_type;

endpackage

// ===== hw/rtl/qvmp_ram.sv =====
// generic single-write, single-read ram with registered read data
module qvmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/qvmp_seq.sv =====
// column and row position counters with count clamping
module qvmp_seq
   import qvmp_pkg::*;
#(
   parameter int MAX_COLS  = MAX_COLS_DEF,
   parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         step,
   input  logic [COL_COUNT_W-1:0]                       column_count,
   input  logic [DEPTH_COUNT_W-1:0]                     depth_count,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col,
   output pos_flags_type                                flags
);

   localparam int ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RowW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int ColCntW = ($clog2(MAX_COLS + 1) > COL_COUNT_W) ?
                            $clog2(MAX_COLS + 1) : COL_COUNT_W;
   localparam int RowCntW = ($clog2(MAX_DEPTH + 1) > DEPTH_COUNT_W) ?
                            $clog2(MAX_DEPTH + 1) : DEPTH_COUNT_W;

   logic [ColW-1:0]    column_pos_ff, column_pos_in;
   logic [RowW-1:0]    row_pos_ff, row_pos_in;
   logic [ColCntW-1:0] cols_raw, cols, col_plus;
   logic [RowCntW-1:0] rows_raw, rows, row_plus;

   always_comb begin
      cols_raw = ColCntW'(column_count);
      if (cols_raw == '0) begin
         cols = ColCntW'(1);
      end else if (cols_raw > ColCntW'(MAX_COLS)) begin
         cols = ColCntW'(MAX_COLS);
      end else begin
         cols = cols_raw;
      end

      rows_raw = RowCntW'(depth_count);
      if (rows_raw == '0) begin
         rows = RowCntW'(1);
      end else if (rows_raw > RowCntW'(MAX_DEPTH)) begin
         rows = RowCntW'(MAX_DEPTH);
      end else begin
         rows = rows_raw;
      end

      col_plus = ColCntW'(column_pos_ff) + ColCntW'(1);
      row_plus = RowCntW'(row_pos_ff) + RowCntW'(1);

      flags.first_row = (row_pos_ff == '0);
      flags.last_col  = (col_plus >= cols);
      flags.last_row  = (row_plus >= rows);

      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (step) begin
         if (flags.last_col) begin
            column_pos_in = '0;
            row_pos_in    = flags.last_row ? '0 : row_plus[RowW-1:0];
         end else begin
            column_pos_in = col_plus[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
      end else begin
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
      end
   end

   assign col = column_pos_ff;

endmodule

// ===== hw/rtl/qvmp_mac.sv =====
// operand stage, multiply-accumulate with bypass, and result register
module qvmp_mac
   import qvmp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] in_col,
   input  pos_flags_type                                in_flags,
   input  logic signed [OPND_W-1:0]                     in_a_diff,
   input  logic signed [OPND_W-1:0]                     in_b_diff,
   input  logic                                         rsp_stall,
   output logic                                         rsp_valid,
   output logic [COL_IDX_W-1:0]                         rsp_column_index,
   output logic signed [SUM_W-1:0]                      rsp_sum_value,
   output logic                                         rsp_last_column,
   output pipe_stat_type                                stat
);

   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic                       s1_valid_ff, s1_valid_in;
   logic [ColW-1:0]            s1_col_ff;
   pos_flags_type              s1_flags_ff;
   logic signed [OPND_W-1:0]   s1_a_ff, s1_b_ff;
   logic                       byp_valid_ff, byp_valid_in;
   logic [SUM_W-1:0]           byp_sum_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [COL_IDX_W-1:0]       out_col_ff;
   logic [SUM_W-1:0]           out_sum_ff;
   logic                       out_last_ff;

   logic                       out_free, advance, emit;
   logic signed [2*OPND_W-1:0] prod;
   logic [SUM_W-1:0]           prod_ext, rd_data, base, sum;
   logic [ColW+COL_IDX_W-1:0]  col_ext;

   qvmp_ram #(
      .WIDTH(SUM_W),
      .DEPTH(MAX_COLS)
   ) u_sums (
      .clock  (clock),
      .wr_en  (advance),
      .wr_addr(s1_col_ff),
      .wr_data(sum),
      .rd_en  (in_valid),
      .rd_addr(in_col),
      .rd_data(rd_data)
   );

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      advance  = s1_valid_ff && (!s1_flags_ff.last_row || out_free);
      emit     = advance && s1_flags_ff.last_row;

      prod     = s1_a_ff * s1_b_ff;
      prod_ext = SUM_W'(prod);
      if (s1_flags_ff.first_row) begin
         base = '0;
      end else if (byp_valid_ff) begin
         base = byp_sum_ff;
      end else begin
         base = rd_data;
      end
      sum     = base + prod_ext;
      col_ext = {{COL_IDX_W{1'b0}}, s1_col_ff};

      s1_valid_in  = in_valid || (s1_valid_ff && !advance);
      byp_valid_in = in_valid ? (advance && (s1_col_ff == in_col)) : byp_valid_ff;
      out_valid_in = out_free ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_col_ff   <= in_col;
         s1_flags_ff <= in_flags;
         s1_a_ff     <= in_a_diff;
         s1_b_ff     <= in_b_diff;
         byp_sum_ff  <= sum;
      end
      if (emit) begin
         out_col_ff  <= col_ext[COL_IDX_W-1:0];
         out_sum_ff  <= sum;
         out_last_ff <= s1_flags_ff.last_col;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_column_index = out_col_ff;
   assign rsp_sum_value    = $signed(out_sum_ff);
   assign rsp_last_column  = out_last_ff;

   assign stat.s1_valid    = s1_valid_ff;
   assign stat.s1_last_row = s1_flags_ff.last_row;
   assign stat.advance     = advance;

endmodule

// ===== hw/rtl/quantized_vector_matrix_product.sv =====
// top level of the quantized vector-matrix product with zero points
//
//  port group  direction  handshake          carries
//  req_        in         req_valid/stall    vector byte, matrix byte, column zero point
//  rsp_        out        rsp_valid/stall    column index, finished sum, last column flag
//  csr_        in         csr_valid/ready    register index and write data
//
// one matrix element per cycle while req_stall is low; a stalled request side holds the element
// operand register and accumulator ram read together, then multiply-add into the result register
// a stalled result holds only an element of the last row; others keep flowing
// reset clears valid flags and positions and loads csr defaults; accumulators need no clearing pass
module quantized_vector_matrix_product
   import qvmp_pkg::*;
#(
   parameter int MAX_COLS  = MAX_COLS_DEF,
   parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [BYTE_W-1:0]        req_vec_byte,
   input  logic [BYTE_W-1:0]        req_mat_byte,
   input  logic signed [ZERO_W-1:0] req_b_zero_column,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COL_IDX_W-1:0]     rsp_column_index,
   output logic signed [SUM_W-1:0]  rsp_sum_value,
   output logic                     rsp_last_column,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

`include "quantized_vector_matrix_product_assert.svh"

   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic                     a_is_signed_ff, b_is_signed_ff, shared_b_zero_ff;
   logic [ZERO_W-1:0]        a_zero_ff, b_zero_common_ff;
   logic [COL_COUNT_W-1:0]   column_count_ff;
   logic [DEPTH_COUNT_W-1:0] depth_count_ff;

   logic                     accept;
   logic [ColW-1:0]          cur_col;
   pos_flags_type            cur_flags;
   pipe_stat_type            stat;
   logic signed [ZERO_W-1:0] a_val, b_val, b_zero;
   logic signed [OPND_W-1:0] a_diff, b_diff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_is_signed_ff   <= 1'b0;
         b_is_signed_ff   <= 1'b0;
         a_zero_ff        <= '0;
         shared_b_zero_ff <= 1'b1;
         b_zero_common_ff <= '0;
         column_count_ff  <= COL_COUNT_RST;
         depth_count_ff   <= DEPTH_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_A_IS_SIGNED:   a_is_signed_ff   <= csr_wdata[0];
            CSR_B_IS_SIGNED:   b_is_signed_ff   <= csr_wdata[0];
            CSR_A_ZERO:        a_zero_ff        <= csr_wdata[ZERO_W-1:0];
            CSR_SHARED_B_ZERO: shared_b_zero_ff <= csr_wdata[0];
            CSR_B_ZERO_COMMON: b_zero_common_ff <= csr_wdata[ZERO_W-1:0];
            CSR_COLUMN_COUNT:  column_count_ff  <= csr_wdata[COL_COUNT_W-1:0];
            CSR_DEPTH_COUNT:   depth_count_ff   <= csr_wdata[DEPTH_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = stat.s1_valid && !stat.advance;

   always_comb begin
      a_val  = $signed({a_is_signed_ff & req_vec_byte[BYTE_W-1], req_vec_byte});
      b_val  = $signed({b_is_signed_ff & req_mat_byte[BYTE_W-1], req_mat_byte});
      b_zero = shared_b_zero_ff ? $signed(b_zero_common_ff) : req_b_zero_column;
      a_diff = OPND_W'(a_val) - OPND_W'($signed(a_zero_ff));
      b_diff = OPND_W'(b_val) - OPND_W'(b_zero);
   end

   qvmp_seq #(
      .MAX_COLS (MAX_COLS),
      .MAX_DEPTH(MAX_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .column_count(column_count_ff),
      .depth_count (depth_count_ff),
      .col         (cur_col),
      .flags       (cur_flags)
   );

   qvmp_mac #(
      .MAX_COLS(MAX_COLS)
   ) u_mac (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .in_col          (cur_col),
      .in_flags        (cur_flags),
      .in_a_diff       (a_diff),
      .in_b_diff       (b_diff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_column_index(rsp_column_index),
      .rsp_sum_value   (rsp_sum_value),
      .rsp_last_column (rsp_last_column),
      .stat            (stat)
   );

   // request side stalls only behind a held last-row result
   `QVMP_ASSERT_IMP(a_stall_cause, req_stall, stat.s1_last_row && rsp_valid && rsp_stall)
   // a last-row element leaving the operand stage becomes a result
   `QVMP_ASSERT_NXT(a_emit_result, stat.advance && stat.s1_last_row, rsp_valid)
   // end of product returns both positions to the start
   `QVMP_ASSERT_NXT(a_pos_wrap, accept && cur_flags.last_col && cur_flags.last_row, (cur_col == '0) && cur_flags.first_row)

endmodule
